/* src/orvm_pkg.sv */
// Shared types, codes and helper functions for the obfuscated register VM step engine.
// No dependencies.
package orvm_pkg;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_ARG   = 2'd1;
  localparam logic [1:0] REQ_EXEC  = 2'd2;

  localparam logic [2:0] ST_CONT   = 3'd0;
  localparam logic [2:0] ST_VALUE  = 3'd1;
  localparam logic [2:0] ST_VOID   = 3'd2;
  localparam logic [2:0] ST_DIVZ   = 3'd3;
  localparam logic [2:0] ST_TAMPER = 3'd4;
  localparam logic [2:0] ST_KIND   = 3'd5;
  localparam logic [2:0] ST_IDLE   = 3'd6;

  localparam logic [2:0] CFG_PROGRAM_ID     = 3'd0;
  localparam logic [2:0] CFG_STATE_MASK     = 3'd1;
  localparam logic [2:0] CFG_OPCODE_XOR     = 3'd2;
  localparam logic [2:0] CFG_OPCODE_BIAS    = 3'd3;
  localparam logic [2:0] CFG_REGISTER_XOR   = 3'd4;
  localparam logic [2:0] CFG_REGISTER_COUNT = 3'd5;
  localparam logic [2:0] CFG_RETURNS_VALUE  = 3'd6;
  localparam logic [2:0] CFG_ENTRY_STATE    = 3'd7;

  localparam logic [1:0] RD_A = 2'd0;
  localparam logic [1:0] RD_B = 2'd1;
  localparam logic [1:0] RD_C = 2'd2;

  localparam logic [31:0] GUARD_SEED = 32'h6D2B79F5;
  localparam logic [31:0] GUARD_INC  = 32'h9E3779B9;

  localparam logic [7:0] OP_NOP    = 8'd0;
  localparam logic [7:0] OP_LDI    = 8'd1;
  localparam logic [7:0] OP_MOV    = 8'd2;
  localparam logic [7:0] OP_NEG    = 8'd3;
  localparam logic [7:0] OP_NOT    = 8'd4;
  localparam logic [7:0] OP_I2B    = 8'd5;
  localparam logic [7:0] OP_I2C    = 8'd6;
  localparam logic [7:0] OP_I2S    = 8'd7;
  localparam logic [7:0] OP_ADD    = 8'd10;
  localparam logic [7:0] OP_SUB    = 8'd11;
  localparam logic [7:0] OP_MUL    = 8'd12;
  localparam logic [7:0] OP_DIV    = 8'd13;
  localparam logic [7:0] OP_REM    = 8'd14;
  localparam logic [7:0] OP_AND    = 8'd15;
  localparam logic [7:0] OP_OR     = 8'd16;
  localparam logic [7:0] OP_XOR    = 8'd17;
  localparam logic [7:0] OP_SHL    = 8'd18;
  localparam logic [7:0] OP_SHR    = 8'd19;
  localparam logic [7:0] OP_USHR   = 8'd20;
  localparam logic [7:0] OP_ADDI   = 8'd21;
  localparam logic [7:0] OP_RSUBI  = 8'd22;
  localparam logic [7:0] OP_MULI   = 8'd23;
  localparam logic [7:0] OP_DIVI   = 8'd24;
  localparam logic [7:0] OP_REMI   = 8'd25;
  localparam logic [7:0] OP_ANDI   = 8'd26;
  localparam logic [7:0] OP_ORI    = 8'd27;
  localparam logic [7:0] OP_XORI   = 8'd28;
  localparam logic [7:0] OP_SHLI   = 8'd29;
  localparam logic [7:0] OP_SHRI   = 8'd30;
  localparam logic [7:0] OP_USHRI  = 8'd31;
  localparam logic [7:0] OP_GOTO   = 8'd40;
  localparam logic [7:0] OP_IFEQ   = 8'd41;
  localparam logic [7:0] OP_IFNE   = 8'd42;
  localparam logic [7:0] OP_IFLT   = 8'd43;
  localparam logic [7:0] OP_IFGE   = 8'd44;
  localparam logic [7:0] OP_IFGT   = 8'd45;
  localparam logic [7:0] OP_IFLE   = 8'd46;
  localparam logic [7:0] OP_CMPEQ  = 8'd47;
  localparam logic [7:0] OP_CMPNE  = 8'd48;
  localparam logic [7:0] OP_CMPLT  = 8'd49;
  localparam logic [7:0] OP_CMPGE  = 8'd50;
  localparam logic [7:0] OP_CMPGT  = 8'd51;
  localparam logic [7:0] OP_CMPLE  = 8'd52;
  localparam logic [7:0] OP_RET    = 8'd60;
  localparam logic [7:0] OP_RETV   = 8'd61;

  typedef struct packed {
    logic       latch;
    logic       simple;
    logic       guard1;
    logic       guard2;
    logic [1:0] rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_c;
    logic       exec;
    logic       div_wb;
    logic       load_out;
  } orvm_cmd_t;

  typedef struct packed {
    logic go_exec;
    logic need_div;
    logic div_busy;
    logic out_free;
  } orvm_sts_t;

  function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} >> n;
    return d[31:0];
  endfunction

  function automatic logic op_known(input logic [7:0] op);
    return (op == OP_NOP) || (op == OP_GOTO) || (op == OP_RETV) || (op == OP_RET) ||
           (op inside {[OP_LDI:OP_I2S]}) || (op inside {[OP_ADD:OP_USHRI]}) ||
           (op inside {[OP_IFEQ:OP_CMPLE]});
  endfunction

  function automatic logic [1:0] op_nregs(input logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    if (op == OP_LDI || op == OP_RET || (op inside {[OP_IFEQ:OP_IFLE]})) n = 2'd1;
    else if ((op inside {[OP_MOV:OP_I2S]}) || (op inside {[OP_ADDI:OP_USHRI]}) ||
             (op inside {[OP_CMPEQ:OP_CMPLE]})) n = 2'd2;
    else if (op inside {[OP_ADD:OP_USHR]}) n = 2'd3;
    return n;
  endfunction

endpackage

/* src/obfuscated_register_vm_step_top.sv */
// Obfuscated register VM step engine, top level: controller plus datapath.
// One item at a time. Start and argument items: captured, result registered, then output loaded.
// Execute items: guard check, operand reads and execute, with a wait on the one-bit-per-cycle
// 32-step divider for register or immediate divide and remainder; next item once the output is loaded.
// Reset (rst, synchronous): configuration to defaults, run stopped, register file reads zero.
module obfuscated_register_vm_step_top #(
  parameter int REG_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [31:0]        cell_state,
  input  logic [7:0]         cell_op,
  input  logic [7:0]         cell_a,
  input  logic [7:0]         cell_b,
  input  logic [7:0]         cell_c,
  input  logic [31:0]        cell_imm,
  input  logic [31:0]        cell_next,
  input  logic [31:0]        cell_branch,
  input  logic [31:0]        cell_guard,
  input  logic [31:0]        cell_noise,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [31:0]        next_state,
  output logic signed [31:0] return_value
);
  import orvm_pkg::*;

  orvm_cmd_t cmd;
  orvm_sts_t sts;

  assign cfg_ready = 1'b1;

  orvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  orvm_dp #(.REG_DEPTH(REG_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .cell_state   (cell_state),
    .cell_op      (cell_op),
    .cell_a       (cell_a),
    .cell_b       (cell_b),
    .cell_c       (cell_c),
    .cell_imm     (cell_imm),
    .cell_next    (cell_next),
    .cell_branch  (cell_branch),
    .cell_guard   (cell_guard),
    .cell_noise   (cell_noise),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .next_state   (next_state),
    .return_value (return_value)
  );

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after transfer");

  a_ret_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_VALUE |-> return_value == 32'sd0)
    else $error("return value set without valued return");

  a_next_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_CONT |-> next_state == 32'd0)
    else $error("next state set on ended run");

endmodule

/* src/orvm_div.sv */
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing.
module orvm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [31:0] acc;
  logic [31:0] q;
  logic [31:0] d;
  logic        q_neg;
  logic        r_neg;
  logic [5:0]  cnt;
  logic [31:0] sh;
  logic [32:0] trial;

  assign sh    = {acc[30:0], q[31]};
  assign trial = {1'b0, sh} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      q     <= dividend[31] ? (32'd0 - dividend) : dividend;
      d     <= divisor[31] ? (32'd0 - divisor) : divisor;
      q_neg <= dividend[31] ^ divisor[31];
      r_neg <= dividend[31];
    end else if (busy) begin
      if (!trial[32]) begin
        acc <= trial[31:0];
        q   <= {q[30:0], 1'b1};
      end else begin
        acc <= sh;
        q   <= {q[30:0], 1'b0};
      end
    end
  end

  assign quo = q_neg ? (32'd0 - q) : q;
  assign rem = r_neg ? (32'd0 - acc) : acc;

endmodule

/* src/orvm_dp.sv */
// Datapath: configuration, register file memory, guard check, decode, ALU and result registers.
// Depends on orvm_pkg and orvm_div.
module orvm_dp #(
  parameter int REG_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  orvm_pkg::orvm_cmd_t cmd,
  output orvm_pkg::orvm_sts_t sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [1:0]         req_type,
  input  logic [31:0]        cell_state,
  input  logic [7:0]         cell_op,
  input  logic [7:0]         cell_a,
  input  logic [7:0]         cell_b,
  input  logic [7:0]         cell_c,
  input  logic [31:0]        cell_imm,
  input  logic [31:0]        cell_next,
  input  logic [31:0]        cell_branch,
  input  logic [31:0]        cell_guard,
  input  logic [31:0]        cell_noise,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [2:0]         status,
  output logic [31:0]        next_state,
  output logic signed [31:0] return_value
);
  import orvm_pkg::*;

  localparam int AW = $clog2(REG_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(REG_DEPTH);

  logic [31:0] pid, smask, entry;
  logic [7:0]  oxor, obias, rxor, rcount;
  logic        rvalue;

  logic [1:0]  req;
  logic [31:0] c_state, c_imm, c_next, c_branch, c_guard, c_noise;
  logic [7:0]  c_op, c_a, c_b, c_c;

  logic [7:0]  op, ia, ib, ic;
  logic [31:0] imm, nxt, br, gv;
  logic        bad;
  logic [31:0] ra, rb, rc;

  logic [31:0] mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] vld;
  logic [31:0] rd_q;
  logic        vld_q;
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_val;

  logic [31:0] cur_state;
  logic        running;
  logic [2:0]  r_status;
  logic [31:0] r_next, r_ret;

  logic        fin_en, wr_en, clr;
  logic [2:0]  fin_status;
  logic [31:0] fin_ns, fin_ret, wr_data, ns;
  logic [AW-1:0] wr_addr;

  logic [31:0] x, alu, mul_lo, v1, v2, v3, v4, q, r;
  logic        taken, is_div, is_wr, need_div, div_busy;
  logic [1:0]  nregs;
  logic        range_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      pid    <= 32'd1;
      smask  <= 32'd1;
      oxor   <= '0;
      obias  <= '0;
      rxor   <= '0;
      rcount <= 8'd255;
      rvalue <= 1'b1;
      entry  <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROGRAM_ID:     pid    <= cfg_data;
        CFG_STATE_MASK:     smask  <= cfg_data;
        CFG_OPCODE_XOR:     oxor   <= cfg_data[7:0];
        CFG_OPCODE_BIAS:    obias  <= cfg_data[7:0];
        CFG_REGISTER_XOR:   rxor   <= cfg_data[7:0];
        CFG_REGISTER_COUNT: rcount <= cfg_data[7:0];
        CFG_RETURNS_VALUE:  rvalue <= cfg_data[0];
        CFG_ENTRY_STATE:    entry  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req      <= req_type;
      c_state  <= cell_state;
      c_op     <= cell_op;
      c_a      <= cell_a;
      c_b      <= cell_b;
      c_c      <= cell_c;
      c_imm    <= cell_imm;
      c_next   <= cell_next;
      c_branch <= cell_branch;
      c_guard  <= cell_guard;
      c_noise  <= cell_noise;
    end
  end

  assign v1 = rol32((GUARD_SEED ^ pid) ^ c_state, 5'd5) + GUARD_INC;
  assign v2 = rol32(v1 ^ {c_op, c_a, c_b, c_c}, 5'd7) + c_imm;
  assign v3 = rol32(gv ^ c_next, 5'd11) + c_branch;
  assign v4 = rol32(v3 ^ c_noise, 5'd13) + smask;

  always_ff @(posedge clk) begin
    if (cmd.guard1) begin
      gv  <= v2;
      op  <= (c_op ^ oxor) - obias;
      ia  <= c_a ^ rxor;
      ib  <= c_b ^ rxor;
      ic  <= c_c ^ rxor;
      imm <= ror32(c_imm, 5'd5 + {1'b0, smask[3:0]}) ^ smask;
      nxt <= c_next ^ rol32(smask, 5'd5);
      br  <= c_branch ^ rol32(smask, 5'd13);
    end
  end

  assign nregs = op_nregs(op);
  always_comb begin
    range_bad = 1'b0;
    if (nregs >= 2'd1 && !(ia < rcount && {1'b0, ia} < DEPTH9)) range_bad = 1'b1;
    if (nregs >= 2'd2 && !(ib < rcount && {1'b0, ib} < DEPTH9)) range_bad = 1'b1;
    if (nregs == 2'd3 && !(ic < rcount && {1'b0, ic} < DEPTH9)) range_bad = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.guard2) begin
      bad <= (v4 != c_guard) || (cur_state == 32'd0) || ((c_state ^ smask) != cur_state) ||
             !op_known(op) || range_bad;
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_A:    rd_addr = ia[AW-1:0];
      RD_B:    rd_addr = ib[AW-1:0];
      RD_C:    rd_addr = ic[AW-1:0];
      default: rd_addr = ia[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rd_q  <= mem[rd_addr];
    vld_q <= vld[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_val = vld_q ? rd_q : 32'd0;

  always_ff @(posedge clk) begin
    if (cmd.cap_a) ra <= rd_val;
    if (cmd.cap_b) rb <= rd_val;
    if (cmd.cap_c) rc <= rd_val;
  end

  assign x      = (op inside {[OP_ADDI:OP_USHRI]}) ? imm : rc;
  assign mul_lo = rb * x;
  assign is_div = (op == OP_DIV) || (op == OP_REM) || (op == OP_DIVI) || (op == OP_REMI);
  assign is_wr  = (op inside {[OP_LDI:OP_I2S]}) || (op inside {[OP_ADD:OP_USHRI]});
  assign need_div = !bad && is_div && (x != 32'd0);

  always_comb begin
    case (op)
      OP_LDI:             alu = imm;
      OP_MOV:             alu = rb;
      OP_NEG:             alu = 32'd0 - rb;
      OP_NOT:             alu = ~rb;
      OP_I2B:             alu = {{24{rb[7]}}, rb[7:0]};
      OP_I2C:             alu = {16'd0, rb[15:0]};
      OP_I2S:             alu = {{16{rb[15]}}, rb[15:0]};
      OP_ADD, OP_ADDI:    alu = rb + x;
      OP_SUB:             alu = rb - rc;
      OP_RSUBI:           alu = imm - rb;
      OP_MUL, OP_MULI:    alu = mul_lo;
      OP_AND, OP_ANDI:    alu = rb & x;
      OP_OR, OP_ORI:      alu = rb | x;
      OP_XOR, OP_XORI:    alu = rb ^ x;
      OP_SHL, OP_SHLI:    alu = rb << x[4:0];
      OP_SHR, OP_SHRI:    alu = $unsigned($signed(rb) >>> x[4:0]);
      OP_USHR, OP_USHRI:  alu = rb >> x[4:0];
      default:            alu = 32'd0;
    endcase
  end

  always_comb begin
    case (op)
      OP_GOTO:  taken = 1'b1;
      OP_IFEQ:  taken = (ra == 32'd0);
      OP_IFNE:  taken = (ra != 32'd0);
      OP_IFLT:  taken = ra[31];
      OP_IFGE:  taken = !ra[31];
      OP_IFGT:  taken = (ra != 32'd0) && !ra[31];
      OP_IFLE:  taken = (ra == 32'd0) || ra[31];
      OP_CMPEQ: taken = (ra == rb);
      OP_CMPNE: taken = (ra != rb);
      OP_CMPLT: taken = $signed(ra) < $signed(rb);
      OP_CMPGE: taken = !($signed(ra) < $signed(rb));
      OP_CMPGT: taken = $signed(rb) < $signed(ra);
      OP_CMPLE: taken = !($signed(rb) < $signed(ra));
      default:  taken = 1'b0;
    endcase
  end

  orvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && need_div),
    .dividend (rb),
    .divisor  (x),
    .busy     (div_busy),
    .quo      (q),
    .rem      (r)
  );

  always_comb begin
    fin_en     = 1'b0;
    fin_status = ST_IDLE;
    fin_ns     = cur_state;
    fin_ret    = 32'd0;
    wr_en      = 1'b0;
    wr_addr    = ia[AW-1:0];
    wr_data    = alu;
    clr        = 1'b0;
    ns         = taken ? br : nxt;
    if (cmd.simple) begin
      fin_en = 1'b1;
      if (req == REQ_START) begin
        clr        = 1'b1;
        fin_status = ST_CONT;
        fin_ns     = entry;
      end else if (req == REQ_ARG && running) begin
        wr_en      = ({1'b0, c_a} < DEPTH9);
        wr_addr    = c_a[AW-1:0];
        wr_data    = c_imm;
        fin_status = ST_CONT;
      end
    end else if (cmd.exec && !need_div) begin
      fin_en = 1'b1;
      if (bad) begin
        fin_status = ST_TAMPER;
      end else if (op == OP_RET) begin
        fin_status = rvalue ? ST_VALUE : ST_KIND;
        fin_ret    = ra;
      end else if (op == OP_RETV) begin
        fin_status = rvalue ? ST_KIND : ST_VOID;
      end else if (is_div) begin
        fin_status = ST_DIVZ;
      end else begin
        wr_en      = is_wr;
        fin_ns     = ns;
        fin_status = (ns == 32'd0) ? ST_TAMPER : ST_CONT;
      end
    end else if (cmd.div_wb) begin
      fin_en     = 1'b1;
      wr_en      = 1'b1;
      wr_data    = (op == OP_DIV || op == OP_DIVI) ? q : r;
      fin_ns     = nxt;
      fin_status = (nxt == 32'd0) ? ST_TAMPER : ST_CONT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      cur_state <= '0;
    end else if (fin_en) begin
      if (fin_status == ST_CONT) begin
        running   <= 1'b1;
        cur_state <= fin_ns;
      end else if (fin_status != ST_IDLE) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_en) begin
      r_status <= fin_status;
      r_next   <= (fin_status == ST_CONT) ? fin_ns : 32'd0;
      r_ret    <= (fin_status == ST_VALUE) ? fin_ret : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= r_status;
      next_state   <= r_next;
      return_value <= $signed(r_ret);
    end
  end

  assign sts.go_exec  = (req == REQ_EXEC) && running;
  assign sts.need_div = need_div;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

/* src/orvm_ctrl.sv */
// Controller: sequences accept, guard check, operand reads, execute, divide and result.
// Depends on orvm_pkg.
module orvm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  orvm_pkg::orvm_sts_t sts,
  output orvm_pkg::orvm_cmd_t cmd
);
  import orvm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_G1   = 4'd2;
  localparam logic [3:0] S_G2   = 4'd3;
  localparam logic [3:0] S_RB   = 4'd4;
  localparam logic [3:0] S_RC   = 4'd5;
  localparam logic [3:0] S_RW   = 4'd6;
  localparam logic [3:0] S_EXEC = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_A;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.go_exec) begin
          state_next = S_G1;
        end else begin
          cmd.simple = 1'b1;
          state_next = S_FIN;
        end
      end
      S_G1: begin
        cmd.guard1 = 1'b1;
        state_next = S_G2;
      end
      S_G2: begin
        cmd.guard2 = 1'b1;
        cmd.rd_sel = RD_A;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_sel = RD_B;
        state_next = S_RC;
      end
      S_RC: begin
        cmd.cap_b  = 1'b1;
        cmd.rd_sel = RD_C;
        state_next = S_RW;
      end
      S_RW: begin
        cmd.cap_c  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.div_wb = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* tb/tb_obfuscated_register_vm_step_top.sv */
// Testbench for obfuscated_register_vm_step_top: encodes register-machine cells, predicts
// every step result and checks each output transfer in order under random idling.
// Depends on orvm_pkg and the top level in src/.
`timescale 1ns / 1ps

module tb_obfuscated_register_vm_step_top;
  import orvm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [1:0]  rq;
    logic [31:0] st;
    logic [7:0]  op, a, b, c;
    logic [31:0] imm, nx, br, gd, nz;
  } cell_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] nstate;
    logic [31:0] retv;
  } outcome_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] req_type;
  logic [31:0] cell_state, cell_imm, cell_next, cell_branch, cell_guard, cell_noise;
  logic [7:0] cell_op, cell_a, cell_b, cell_c;
  logic out_valid, out_stall;
  logic [2:0] status;
  logic [31:0] next_state;
  logic signed [31:0] return_value;

  obfuscated_register_vm_step_top u_top (.*);

  // model state
  logic [31:0] m_pid, m_mask, m_entry, m_cur;
  logic [7:0]  m_oxor, m_obias, m_rxor, m_rcount;
  logic        m_retval, m_running;
  logic [31:0] m_regs [256];

  outcome_t pending_outcomes[$];
  int errors, cycles, items_sent;
  int send_idle_pct, stall_pct, hold_left;

  int valid_ops[] = '{0, 1, 2, 3, 4, 5, 6, 7, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20,
                      21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 40, 41, 42, 43, 44, 45,
                      46, 47, 48, 49, 50, 51, 52};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    n = n & 31;
    return n == 0 ? v : (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] rotr(logic [31:0] v, int n);
    n = n & 31;
    return n == 0 ? v : (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] guard_of(cell_t c);
    logic [31:0] v;
    v = GUARD_SEED ^ m_pid;
    v = rotl(v ^ c.st, 5) + GUARD_INC;
    v = rotl(v ^ {c.op, c.a, c.b, c.c}, 7) + c.imm;
    v = rotl(v ^ c.nx, 11) + c.br;
    return rotl(v ^ c.nz, 13) + m_mask;
  endfunction

  function automatic int reg_operands(logic [7:0] op);
    if (op == OP_NOP || op == OP_GOTO || op == OP_RETV) return 0;
    if (op == OP_LDI || op == OP_RET || (op >= OP_IFEQ && op <= OP_IFLE)) return 1;
    if ((op >= OP_MOV && op <= OP_I2S) || (op >= OP_ADDI && op <= OP_USHRI) ||
        (op >= OP_CMPEQ && op <= OP_CMPLE)) return 2;
    if (op >= OP_ADD && op <= OP_USHR) return 3;
    return -1;
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] x, logic [31:0] y);
    if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) return x;
    return $signed(x) / $signed(y);
  endfunction

  function automatic logic [31:0] srem(logic [31:0] x, logic [31:0] y);
    if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) return 0;
    return $signed(x) % $signed(y);
  endfunction

  function automatic logic [2:0] exec_cell(cell_t c, output logic [31:0] ns_o,
                                           output logic [31:0] rv_o);
    logic [7:0] op, a, b, c2;
    logic [31:0] imm, nxt, br, ra, rb, rc, res, nsv;
    logic wr, taken;
    int n;
    ns_o = 0; rv_o = 0; res = 0; wr = 1'b1; taken = 1'b0;
    if (guard_of(c) != c.gd) return ST_TAMPER;
    if (m_cur == 0 || (c.st ^ m_mask) != m_cur) return ST_TAMPER;
    op = (c.op ^ m_oxor) - m_obias;
    a = c.a ^ m_rxor; b = c.b ^ m_rxor; c2 = c.c ^ m_rxor;
    imm = rotr(c.imm, 5 + m_mask[3:0]) ^ m_mask;
    nxt = c.nx ^ rotl(m_mask, 5);
    br = c.br ^ rotl(m_mask, 13);
    n = reg_operands(op);
    if (n < 0) return ST_TAMPER;
    if ((n >= 1 && a >= m_rcount) || (n >= 2 && b >= m_rcount) || (n >= 3 && c2 >= m_rcount))
      return ST_TAMPER;
    ra = m_regs[a]; rb = m_regs[b]; rc = m_regs[c2];
    if (op == OP_RET) begin
      if (!m_retval) return ST_KIND;
      rv_o = ra;
      return ST_VALUE;
    end
    if (op == OP_RETV) return m_retval ? ST_KIND : ST_VOID;
    case (op)
      OP_LDI:   res = imm;
      OP_MOV:   res = rb;
      OP_NEG:   res = -rb;
      OP_NOT:   res = ~rb;
      OP_I2B:   res = {{24{rb[7]}}, rb[7:0]};
      OP_I2C:   res = {16'h0, rb[15:0]};
      OP_I2S:   res = {{16{rb[15]}}, rb[15:0]};
      OP_ADD:   res = rb + rc;
      OP_SUB:   res = rb - rc;
      OP_MUL:   res = rb * rc;
      OP_DIV:   begin if (rc == 0) return ST_DIVZ; res = sdiv(rb, rc); end
      OP_REM:   begin if (rc == 0) return ST_DIVZ; res = srem(rb, rc); end
      OP_AND:   res = rb & rc;
      OP_OR:    res = rb | rc;
      OP_XOR:   res = rb ^ rc;
      OP_SHL:   res = rb << rc[4:0];
      OP_SHR:   res = $signed(rb) >>> rc[4:0];
      OP_USHR:  res = rb >> rc[4:0];
      OP_ADDI:  res = rb + imm;
      OP_RSUBI: res = imm - rb;
      OP_MULI:  res = rb * imm;
      OP_DIVI:  begin if (imm == 0) return ST_DIVZ; res = sdiv(rb, imm); end
      OP_REMI:  begin if (imm == 0) return ST_DIVZ; res = srem(rb, imm); end
      OP_ANDI:  res = rb & imm;
      OP_ORI:   res = rb | imm;
      OP_XORI:  res = rb ^ imm;
      OP_SHLI:  res = rb << imm[4:0];
      OP_SHRI:  res = $signed(rb) >>> imm[4:0];
      OP_USHRI: res = rb >> imm[4:0];
      default: begin
        wr = 1'b0;
        case (op)
          OP_GOTO:  taken = 1'b1;
          OP_IFEQ:  taken = ra == 0;
          OP_IFNE:  taken = ra != 0;
          OP_IFLT:  taken = ra[31];
          OP_IFGE:  taken = !ra[31];
          OP_IFGT:  taken = ra != 0 && !ra[31];
          OP_IFLE:  taken = ra == 0 || ra[31];
          OP_CMPEQ: taken = ra == rb;
          OP_CMPNE: taken = ra != rb;
          OP_CMPLT: taken = $signed(ra) < $signed(rb);
          OP_CMPGE: taken = !($signed(ra) < $signed(rb));
          OP_CMPGT: taken = $signed(rb) < $signed(ra);
          OP_CMPLE: taken = !($signed(rb) < $signed(ra));
          default:  taken = 1'b0;
        endcase
      end
    endcase
    if (wr) m_regs[a] = res;
    nsv = taken ? br : nxt;
    if (nsv == 0) return ST_TAMPER;
    m_cur = nsv;
    ns_o = nsv;
    return ST_CONT;
  endfunction

  function automatic outcome_t vm_step_model(cell_t c);
    outcome_t o;
    o.status = ST_IDLE; o.nstate = 0; o.retv = 0;
    if (c.rq == REQ_START) begin
      foreach (m_regs[i]) m_regs[i] = 0;
      m_cur = m_entry;
      m_running = 1'b1;
      o.status = ST_CONT;
      o.nstate = m_cur;
    end else if (c.rq == REQ_ARG && m_running) begin
      m_regs[c.a] = c.imm;
      o.status = ST_CONT;
      o.nstate = m_cur;
    end else if (c.rq == REQ_EXEC && m_running) begin
      o.status = exec_cell(c, o.nstate, o.retv);
      if (o.status != ST_CONT) begin
        m_running = 1'b0;
        o.nstate = 0;
      end
      if (o.status != ST_VALUE) o.retv = 0;
    end
    return o;
  endfunction

  function automatic cell_t encode(logic [7:0] op, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                   logic [31:0] imm, logic [31:0] nxt, logic [31:0] br);
    cell_t e;
    e.rq = REQ_EXEC;
    e.st = m_cur ^ m_mask;
    e.op = (op + m_obias) ^ m_oxor;
    e.a = a ^ m_rxor; e.b = b ^ m_rxor; e.c = c ^ m_rxor;
    e.imm = rotl(imm ^ m_mask, 5 + m_mask[3:0]);
    e.nx = nxt ^ rotl(m_mask, 5);
    e.br = br ^ rotl(m_mask, 13);
    e.nz = $urandom;
    e.gd = guard_of(e);
    return e;
  endfunction

  function automatic cell_t plain(logic [1:0] rq, logic [7:0] idx, logic [31:0] val);
    cell_t e;
    e.rq = rq; e.st = $urandom; e.op = $urandom; e.a = idx; e.b = $urandom; e.c = $urandom;
    e.imm = val; e.nx = $urandom; e.br = $urandom; e.gd = $urandom; e.nz = $urandom;
    return e;
  endfunction

  function automatic logic [31:0] nz_state();
    logic [31:0] s;
    s = $urandom;
    return s == 0 ? 32'd1 : s;
  endfunction

  function automatic logic [31:0] edge_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 0;
      4: return $urandom_range(63);
      default: return $urandom;
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        report("unexpected transfer", {29'd0, status}, 0);
      end else begin
        w = pending_outcomes.pop_front();
        if (status !== w.status) report("status", {29'd0, status}, {29'd0, w.status});
        if (next_state !== w.nstate) report("next_state", next_state, w.nstate);
        if (return_value !== w.retv) report("return_value", return_value, w.retv);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(cell_t c);
    req_type = c.rq; cell_state = c.st; cell_op = c.op; cell_a = c.a; cell_b = c.b;
    cell_c = c.c; cell_imm = c.imm; cell_next = c.nx; cell_branch = c.br;
    cell_guard = c.gd; cell_noise = c.nz;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_outcomes.insert(pending_outcomes.size(), vm_step_model(c));
    items_sent++;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_index = idx; cfg_data = val; cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PROGRAM_ID:     m_pid = val;
      CFG_STATE_MASK:     m_mask = val;
      CFG_OPCODE_XOR:     m_oxor = val[7:0];
      CFG_OPCODE_BIAS:    m_obias = val[7:0];
      CFG_REGISTER_XOR:   m_rxor = val[7:0];
      CFG_REGISTER_COUNT: m_rcount = val[7:0];
      CFG_RETURNS_VALUE:  m_retval = val[0];
      CFG_ENTRY_STATE:    m_entry = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(logic [31:0] pid, logic [31:0] mask, logic [7:0] ox,
                                logic [7:0] ob, logic [7:0] rx, logic [7:0] cnt, logic rv,
                                logic [31:0] ent);
    wait_idle();
    cfg_write(CFG_PROGRAM_ID, pid);
    cfg_write(CFG_STATE_MASK, mask);
    cfg_write(CFG_OPCODE_XOR, {24'd0, ox});
    cfg_write(CFG_OPCODE_BIAS, {24'd0, ob});
    cfg_write(CFG_REGISTER_XOR, {24'd0, rx});
    cfg_write(CFG_REGISTER_COUNT, {24'd0, cnt});
    cfg_write(CFG_RETURNS_VALUE, {31'd0, rv});
    cfg_write(CFG_ENTRY_STATE, ent);
  endtask

  function automatic logic [31:0] pick32(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(2))
      0: return lo;
      1: return hi;
      default: return ($urandom | lo);
    endcase
  endfunction

  task automatic random_settings();
    logic [7:0] cnt;
    case ($urandom_range(3))
      0: cnt = 1;
      1: cnt = 255;
      default: cnt = $urandom_range(2, 16);
    endcase
    apply_settings(pick32(1, 32'hFFFF_FFFF), pick32(1, 32'hFFFF_FFFF),
                   pick32(0, 255), pick32(0, 255), pick32(0, 255), cnt, $urandom_range(1),
                   pick32(1, 32'hFFFF_FFFF));
  endtask

  function automatic logic [7:0] pick_reg();
    if ($urandom_range(99) < 3) return $urandom_range(m_rcount, 255);
    return $urandom_range(m_rcount - 1);
  endfunction

  function automatic logic [7:0] unknown_op();
    logic [7:0] op;
    do op = $urandom; while (reg_operands(op) >= 0);
    return op;
  endfunction

  // one start, a few argument writes, a random instruction stream and, if still running, a return
  task automatic run_program();
    cell_t e;
    logic [7:0] op;
    logic [31:0] imm;
    int steps;
    send_item(plain(REQ_START, $urandom, $urandom));
    repeat ($urandom_range(0, 4))
      send_item(plain(REQ_ARG, $urandom_range(99) < 90 ? pick_reg() : $urandom, edge_word()));
    steps = $urandom_range(1, 12);
    for (int i = 0; i < steps && m_running; i++) begin
      op = valid_ops[$urandom_range(valid_ops.size() - 1)];
      if ($urandom_range(99) < 2) op = unknown_op();
      imm = edge_word();
      e = encode(op, pick_reg(), pick_reg(), pick_reg(), imm,
                 $urandom_range(99) < 2 ? 32'd0 : nz_state(), nz_state());
      case ($urandom_range(99))
        0: e.gd[$urandom_range(31)] ^= 1'b1;
        1: e.st ^= 32'h1 << $urandom_range(31);
        2: e = plain(2'd3, $urandom, $urandom);
        3: e = plain(REQ_ARG, $urandom, $urandom);
        default: ;
      endcase
      send_item(e);
    end
    if (m_running)
      send_item(encode(($urandom_range(99) < 80) == m_retval ? OP_RET : OP_RETV, pick_reg(),
                       $urandom, $urandom, $urandom, nz_state(), nz_state()));
    if ($urandom_range(99) < 5)
      send_item($urandom_range(1) ? encode(OP_NOP, 0, 0, 0, 0, 1, 1)
                                  : plain(2'd3, $urandom, $urandom));
  endtask

  task automatic test_directed();
    send_idle_pct = 0; stall_pct = 0;
    send_item(encode(OP_NOP, 0, 0, 0, 0, 1, 1));
    send_item(plain(2'd3, 8'hFF, 32'hFFFF_FFFF));
    send_item(plain(REQ_ARG, 8'h00, 32'h1));
    send_item(plain(REQ_START, 0, 0));
    send_item(plain(REQ_ARG, 8'd0, 32'h8000_0000));
    send_item(plain(REQ_ARG, 8'd1, 32'hFFFF_FFFF));
    send_item(plain(REQ_ARG, 8'd254, 32'h7FFF_FFFF));
    send_item(plain(REQ_ARG, 8'd255, 32'h1234_5678));
    send_item(encode(OP_DIV, 3, 0, 1, 0, 32'hFFFF_FFFF, 5));
    send_item(encode(OP_REM, 4, 0, 1, 0, 32'h2, 5));
    send_item(encode(OP_DIVI, 5, 254, 0, 32'hFFFF_FFFF, 32'h3, 5));
    send_item(encode(OP_SHRI, 6, 0, 0, 32'd31, 32'h4, 5));
    send_item(encode(OP_CMPLT, 0, 254, 0, 0, 32'h6, 32'h7));
    send_item(encode(OP_LDI, 254, 0, 0, 32'hFFFF_FFFF, 32'h8, 5));
    send_item(encode(OP_RET, 255, 0, 0, 0, 32'h9, 5));
    send_item(encode(OP_NOP, 0, 0, 0, 0, 1, 1));
    send_item(plain(REQ_START, 0, 0));
    send_item(encode(OP_DIV, 3, 0, 2, 0, 32'h2, 5));
    send_item(plain(REQ_START, 0, 0));
    send_item(encode(OP_GOTO, 0, 0, 0, 0, 5, 0));
    send_item(plain(REQ_START, 0, 0));
    send_item(encode(OP_RETV, 0, 0, 0, 0, 1, 1));
    send_item(plain(REQ_START, 0, 0));
    send_item(encode(unknown_op(), 0, 0, 0, 0, 1, 1));
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b0,
                   32'hFFFF_FFFF);
    send_item(plain(REQ_START, 0, 0));
    send_item(encode(OP_RETV, 0, 0, 0, 0, 1, 1));
    send_item(plain(REQ_START, 0, 0));
    send_item(encode(OP_RET, 0, 0, 0, 0, 1, 1));
    wait_idle();
  endtask

  task automatic test_random_phase(int sidle, int rstall, int count);
    int goal;
    send_idle_pct = sidle; stall_pct = rstall;
    random_settings();
    goal = items_sent + count;
    while (items_sent < goal) run_program();
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; stall_pct = 0;
    random_settings();
    hold_left = 300;
    repeat (4) run_program();
    wait_idle();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 36; stall_pct = 36;
    run_program();
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    run_program();
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
    req_type = 0; cell_state = 0; cell_op = 0; cell_a = 0; cell_b = 0; cell_c = 0;
    cell_imm = 0; cell_next = 0; cell_branch = 0; cell_guard = 0; cell_noise = 0;
    out_stall = 0; hold_left = 0; errors = 0; cycles = 0; items_sent = 0;
    send_idle_pct = 0; stall_pct = 0;
    m_pid = 1; m_mask = 1; m_oxor = 0; m_obias = 0; m_rxor = 0; m_rcount = 255;
    m_retval = 1; m_entry = 1; m_cur = 0; m_running = 0;
    foreach (m_regs[i]) m_regs[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    for (int p = 0; p < 2; p++) begin
      test_random_phase(0, 0, 200);
      test_random_phase(73, 0, 200);
      test_random_phase(0, 73, 200);
      test_random_phase(36, 36, 200);
    end
    test_backpressure();
    test_drain_pause();
    wait_idle();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
